// ----- rtl/rgbc_color_classifier_unit_defines.svh -----
// assertion macros for the rgbc color classifier
// they expect clk_i and rst_ni in the scope where they are used
`ifndef RGBC_COLOR_CLASSIFIER_UNIT_DEFINES_SVH
`define RGBC_COLOR_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RGBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgbc: check failed");
// next-cycle implication
`define RGBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgbc: check failed");
`else
`define RGBC_ASSERT_IMPL(lbl, ante, cons)
`define RGBC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rgbc_pkg.sv -----
package rgbc_pkg;

  // field widths
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned NORM_W     = 9;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned PROD_W     = 2 * NORM_W;
  localparam int unsigned CH_N       = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // channel slots
  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;

  // saturation value and unity in 1/256 units
  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam logic [NORM_W-1:0] TOL_ONE  = 9'd256;

  // register reset values
  localparam logic [TOL_W-1:0]  TIGHT_RST = 8'd51;
  localparam logic [TOL_W-1:0]  LOOSE_RST = 8'd102;
  localparam logic [NORM_W-1:0] WHITE_RST = 9'd78;

  typedef enum logic [2:0] {
    COL_RED    = 3'd0,
    COL_GREEN  = 3'd1,
    COL_BLUE   = 3'd2,
    COL_YELLOW = 3'd3,
    COL_BLACK  = 3'd4,
    COL_WHITE  = 3'd5
  } color_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIGHT = 2'd0,
    CFG_LOOSE = 2'd1,
    CFG_WHITE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TOL_W-1:0]  tight;
    logic [TOL_W-1:0]  loose;
    logic [NORM_W-1:0] white;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] red_raw;
    logic [RAW_W-1:0] green_raw;
    logic [RAW_W-1:0] blue_raw;
    logic [RAW_W-1:0] clear_raw;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        color_code;
    logic [NORM_W-1:0] red_norm;
    logic [NORM_W-1:0] green_norm;
    logic [NORM_W-1:0] blue_norm;
    logic              zero_clear;
  } out_beat_t;

  // divider result handed to the classifier
  typedef struct packed {
    logic [CH_N-1:0][NORM_W-1:0] quo;
    logic [CH_N-1:0]             sat;
    logic                        zero;
  } div_res_t;

endpackage

// ----- rtl/rgbc_stream_if.sv -----
interface rgbc_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rgbc_div_stage.sv -----
module rgbc_div_stage #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter bit          FIRST       = 1'b0
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [rgbc_pkg::CH_N-1:0][SAMPLE_BITS:0]         rem_i,
  input  logic [rgbc_pkg::CH_N-1:0][rgbc_pkg::NORM_W-1:0]  quo_i,
  input  logic [rgbc_pkg::CH_N-1:0]                        sat_i,
  input  logic [SAMPLE_BITS-1:0]                           dvs_i,
  input  logic                                             zero_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [rgbc_pkg::CH_N-1:0][SAMPLE_BITS:0]         rem_o,
  output logic [rgbc_pkg::CH_N-1:0][rgbc_pkg::NORM_W-1:0]  quo_o,
  output logic [rgbc_pkg::CH_N-1:0]                        sat_o,
  output logic [SAMPLE_BITS-1:0]                           dvs_o,
  output logic                                             zero_o
);

  localparam int unsigned RW = SAMPLE_BITS + 1;

  logic                                            valid_q;
  logic [rgbc_pkg::CH_N-1:0][RW-1:0]               shf;
  logic [rgbc_pkg::CH_N-1:0]                       ge;
  logic [RW-1:0]                                   dvs_ext;
  logic [rgbc_pkg::CH_N-1:0][RW-1:0]               rem_d, rem_q;
  logic [rgbc_pkg::CH_N-1:0][rgbc_pkg::NORM_W-1:0] quo_d, quo_q;
  logic [rgbc_pkg::CH_N-1:0]                       sat_d, sat_q;
  logic [SAMPLE_BITS-1:0]                          dvs_q;
  logic                                            zero_q;

  // stage takes a beat when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  // one restoring step per channel: first stage compares the raw value,
  // later ones the doubled remainder
  assign dvs_ext = {1'b0, dvs_i};
  always_comb begin
    for (int c = 0; c < rgbc_pkg::CH_N; c++) begin
      shf[c]   = FIRST ? rem_i[c] : {rem_i[c][RW-2:0], 1'b0};
      ge[c]    = shf[c] >= dvs_ext;
      rem_d[c] = ge[c] ? shf[c] - dvs_ext : shf[c];
      quo_d[c] = {quo_i[c][rgbc_pkg::NORM_W-2:0], ge[c]};
      // quotient reaches 512 when the channel is at least twice clear
      sat_d[c] = FIRST ? (rem_i[c] >= {dvs_i, 1'b0}) : sat_i[c];
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      sat_q  <= sat_d;
      dvs_q  <= dvs_i;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign sat_o   = sat_q;
  assign dvs_o   = dvs_q;
  assign zero_o  = zero_q;

endmodule

// ----- rtl/rgbc_classifier.sv -----
module rgbc_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgbc_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  rgbc_pkg::div_res_t  res_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rgbc_pkg::out_beat_t beat_o
);

  localparam int unsigned NW = rgbc_pkg::NORM_W;
  localparam int unsigned PW = rgbc_pkg::PROD_W;

  // stage control
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage 1: saturated norms
  logic [rgbc_pkg::CH_N-1:0][NW-1:0] n1_d, n1_q;
  logic                              z1_q;

  // stage 2: tolerance bounds for red
  logic [NW-1:0]                     t_lo_f, t_hi_f, l_lo_f, l_hi_f;
  logic [PW-1:0]                     t_lo_d, t_hi_d, l_lo_d, l_hi_d;
  logic [PW-1:0]                     t_lo_q, t_hi_q, l_lo_q, l_hi_q;
  logic [rgbc_pkg::CH_N-1:0][NW-1:0] n2_q;
  logic                              z2_q;

  // stage 3: classification
  logic [PW-1:0]         mid_g, mid_b;
  logic                  tight_g, tight_b, loose_g;
  rgbc_pkg::color_e      code_d;
  rgbc_pkg::out_beat_t   beat_d, beat_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // saturate, or clear everything for a zero clear reading
  always_comb begin
    for (int c = 0; c < rgbc_pkg::CH_N; c++) begin
      if (res_i.zero) begin
        n1_d[c] = '0;
      end else if (res_i.sat[c]) begin
        n1_d[c] = rgbc_pkg::NORM_MAX;
      end else begin
        n1_d[c] = res_i.quo[c];
      end
    end
  end

  // bounds red*(256-t) and red*(256+t) for both tolerances
  assign t_lo_f = rgbc_pkg::TOL_ONE - {1'b0, cfg_i.tight};
  assign t_hi_f = rgbc_pkg::TOL_ONE + {1'b0, cfg_i.tight};
  assign l_lo_f = rgbc_pkg::TOL_ONE - {1'b0, cfg_i.loose};
  assign l_hi_f = rgbc_pkg::TOL_ONE + {1'b0, cfg_i.loose};
  assign t_lo_d = PW'(n1_q[rgbc_pkg::CH_R]) * PW'(t_lo_f);
  assign t_hi_d = PW'(n1_q[rgbc_pkg::CH_R]) * PW'(t_hi_f);
  assign l_lo_d = PW'(n1_q[rgbc_pkg::CH_R]) * PW'(l_lo_f);
  assign l_hi_d = PW'(n1_q[rgbc_pkg::CH_R]) * PW'(l_hi_f);

  // range tests against green and blue scaled by 256
  assign mid_g   = {1'b0, n2_q[rgbc_pkg::CH_G], 8'b0};
  assign mid_b   = {1'b0, n2_q[rgbc_pkg::CH_B], 8'b0};
  assign tight_g = (t_lo_q <= mid_g) && (mid_g <= t_hi_q);
  assign tight_b = (t_lo_q <= mid_b) && (mid_b <= t_hi_q);
  assign loose_g = (l_lo_q <= mid_g) && (mid_g <= l_hi_q);

  // color decision, first match wins
  always_comb begin
    priority if (z2_q) begin
      code_d = rgbc_pkg::COL_BLACK;
    end else if (tight_g && tight_b) begin
      code_d = (n2_q[rgbc_pkg::CH_R] >= cfg_i.white) ? rgbc_pkg::COL_WHITE
                                                      : rgbc_pkg::COL_BLACK;
    end else if (loose_g) begin
      code_d = rgbc_pkg::COL_YELLOW;
    end else if ((n2_q[rgbc_pkg::CH_R] > n2_q[rgbc_pkg::CH_G]) &&
                 (n2_q[rgbc_pkg::CH_R] > n2_q[rgbc_pkg::CH_B])) begin
      code_d = rgbc_pkg::COL_RED;
    end else if (n2_q[rgbc_pkg::CH_B] > n2_q[rgbc_pkg::CH_G]) begin
      code_d = rgbc_pkg::COL_BLUE;
    end else begin
      code_d = rgbc_pkg::COL_GREEN;
    end
  end

  always_comb begin
    beat_d.color_code = code_d;
    beat_d.red_norm   = n2_q[rgbc_pkg::CH_R];
    beat_d.green_norm = n2_q[rgbc_pkg::CH_G];
    beat_d.blue_norm  = n2_q[rgbc_pkg::CH_B];
    beat_d.zero_clear = z2_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      n1_q <= n1_d;
      z1_q <= res_i.zero;
    end
    if (rdy2) begin
      t_lo_q <= t_lo_d;
      t_hi_q <= t_hi_d;
      l_lo_q <= l_lo_d;
      l_hi_q <= l_hi_d;
      n2_q   <= n1_q;
      z2_q   <= z1_q;
    end
    if (rdy3) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = v3_q;
  assign beat_o  = beat_q;

endmodule

// ----- rtl/rgbc_color_classifier_unit.sv -----
// rgbc color classifier
// in_i carries one raw red, green, blue and clear reading per beat; out_o
// returns one beat per reading with the color code, the three channels
// normalized to 256*channel/clear (saturated at 511) and a flag for a
// zero clear reading, which always comes out black with zero norms.
// both channels are valid/ready; a beat moves when both are high.
// cfg_we_i writes register cfg_idx_i (0 tight tolerance, 1 loose
// tolerance, 2 white level) from cfg_data_i; other indexes are dropped.
// write only while no reading is in flight.
// a reading passes through the one-bit-per-stage restoring divider,
// then through the saturate, multiply and compare stages.
// throughput: one reading per cycle while out_o takes beats, set by
// the per-stage divider step.
// every stage holds its own valid bit, so while out_o stalls the pipe
// keeps taking readings until every stage is full; nothing is dropped.
// reset empties the pipe and loads the registers with 51, 102 and 78.
`include "rgbc_color_classifier_unit_defines.svh"

module rgbc_color_classifier_unit #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rgbc_stream_if.sink                        in_i,
  rgbc_stream_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned STEPS = rgbc_pkg::NORM_W;
  localparam int unsigned RW    = SAMPLE_BITS + 1;

  // configuration registers
  rgbc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tight <= rgbc_pkg::TIGHT_RST;
      cfg_q.loose <= rgbc_pkg::LOOSE_RST;
      cfg_q.white <= rgbc_pkg::WHITE_RST;
    end else if (cfg_we_i) begin
      unique case (rgbc_pkg::cfg_idx_e'(cfg_idx_i))
        rgbc_pkg::CFG_TIGHT: cfg_q.tight <= cfg_data_i[rgbc_pkg::TOL_W-1:0];
        rgbc_pkg::CFG_LOOSE: cfg_q.loose <= cfg_data_i[rgbc_pkg::TOL_W-1:0];
        rgbc_pkg::CFG_WHITE: cfg_q.white <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider chain, boundary k feeds stage k
  logic [STEPS:0]                                         vld;
  logic [STEPS:0]                                         rdy;
  logic [STEPS:0][rgbc_pkg::CH_N-1:0][RW-1:0]             rem;
  logic [STEPS:0][rgbc_pkg::CH_N-1:0][rgbc_pkg::NORM_W-1:0] quo;
  logic [STEPS:0][rgbc_pkg::CH_N-1:0]                     sat;
  logic [STEPS:0][SAMPLE_BITS-1:0]                        dvs;
  logic [STEPS:0]                                         zero;

  // input beat, trimmed to the sample width
  assign vld[0]             = in_i.valid;
  assign in_i.ready         = rdy[0];
  assign rem[0][rgbc_pkg::CH_R] = {1'b0, SAMPLE_BITS'(in_i.data.red_raw)};
  assign rem[0][rgbc_pkg::CH_G] = {1'b0, SAMPLE_BITS'(in_i.data.green_raw)};
  assign rem[0][rgbc_pkg::CH_B] = {1'b0, SAMPLE_BITS'(in_i.data.blue_raw)};
  assign quo[0]             = '0;
  assign sat[0]             = '0;
  assign dvs[0]             = SAMPLE_BITS'(in_i.data.clear_raw);
  assign zero[0]            = (dvs[0] == '0);

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    rgbc_div_stage #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FIRST       (k == 0)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .rem_i   (rem[k]),
      .quo_i   (quo[k]),
      .sat_i   (sat[k]),
      .dvs_i   (dvs[k]),
      .zero_i  (zero[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .rem_o   (rem[k+1]),
      .quo_o   (quo[k+1]),
      .sat_o   (sat[k+1]),
      .dvs_o   (dvs[k+1]),
      .zero_o  (zero[k+1])
    );
  end

  // quotient, saturation and zero flag into the classifier
  rgbc_pkg::div_res_t  div_res;
  rgbc_pkg::out_beat_t beat;

  assign div_res.quo  = quo[STEPS];
  assign div_res.sat  = sat[STEPS];
  assign div_res.zero = zero[STEPS];

  rgbc_classifier u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (vld[STEPS]),
    .ready_o (rdy[STEPS]),
    .res_i   (div_res),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .beat_o  (beat)
  );

  assign out_o.data = beat;

  // checks
  `RGBC_ASSERT_NEXT(a_take_fills_first, in_i.valid && in_i.ready, vld[1])
  `RGBC_ASSERT_IMPL(a_zero_is_black, out_o.valid && beat.zero_clear,
                    (beat.color_code == rgbc_pkg::COL_BLACK) && (beat.red_norm == '0) &&
                    (beat.green_norm == '0) && (beat.blue_norm == '0))
  `RGBC_ASSERT_IMPL(a_white_level, out_o.valid && (beat.color_code == rgbc_pkg::COL_WHITE),
                    beat.red_norm >= cfg_q.white)
  `RGBC_ASSERT_IMPL(a_red_dominant, out_o.valid && (beat.color_code == rgbc_pkg::COL_RED),
                    (beat.red_norm > beat.green_norm) && (beat.red_norm > beat.blue_norm))

endmodule
